// File: rtl/rce_pkg.sv
package rce_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_HEIGHT   = 4096;
    localparam int CHAN_W       = 8;
    localparam int COL_W        = 10;
    localparam int ROW_W        = 12;
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_IDX_W    = 2;
    localparam int DIAG_W       = 10;
    localparam int SUM_W        = 11;
    localparam int SAT_LIMIT    = 255;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_AW     = 2;
    localparam int NUM_KINDS    = 3;

    // Bit positions in the kinds vector of a job, in the order results leave.
    localparam int KIND_EDGE  = 0;
    localparam int KIND_UPPER = 1;
    localparam int KIND_SELF  = 2;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_IMAGE_WIDTH  = cfg_idx_t'(0);
    localparam cfg_idx_t CFG_IMAGE_HEIGHT = cfg_idx_t'(1);

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
        logic [COL_W-1:0]  column;
        logic [ROW_W-1:0]  row;
        logic              is_edge;
        logic              last_of_run;
    } result_t;

    typedef struct packed {
        logic [CHAN_W-1:0]    magnitude;
        pixel_t               upper;
        pixel_t               cur;
        logic [COL_W-1:0]     col;
        logic [ROW_W-1:0]     row;
        logic [NUM_KINDS-1:0] kinds;
    } job_t;

    function automatic logic [CHAN_W-1:0] absdiff(input logic [CHAN_W-1:0] a,
                                                  input logic [CHAN_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic logic [DIAG_W-1:0] diag_sum(input pixel_t p, input pixel_t q);
        return DIAG_W'(absdiff(p.red, q.red)) + DIAG_W'(absdiff(p.green, q.green))
             + DIAG_W'(absdiff(p.blue, q.blue));
    endfunction

    // Returns the last valid column for a written width value.
    function automatic logic [COL_W-1:0] width_last(input logic [WIDTH_REG_W-1:0] v);
        logic [COL_W-1:0] res;
        if (v == '0)
            res = '0;
        else if (v > WIDTH_REG_W'(MAX_WIDTH))
            res = COL_W'(MAX_WIDTH - 1);
        else
            res = COL_W'(v - WIDTH_REG_W'(1));
        return res;
    endfunction

    // Returns the last valid row for a written height value.
    function automatic logic [ROW_W-1:0] height_last(input logic [HEIGHT_REG_W-1:0] v);
        logic [ROW_W-1:0] res;
        if (v == '0)
            res = '0;
        else if (v > HEIGHT_REG_W'(MAX_HEIGHT))
            res = ROW_W'(MAX_HEIGHT - 1);
        else
            res = ROW_W'(v - HEIGHT_REG_W'(1));
        return res;
    endfunction

endpackage

// File: rtl/rce_front.sv
module rce_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  rce_pkg::pixel_t                pixel,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  rce_pkg::cfg_idx_t              cfg_index,
    input  logic [rce_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                           job_push,
    output rce_pkg::job_t                  job,
    input  logic                           job_full
);

    logic [rce_pkg::COL_W-1:0] width_last_reg;
    logic [rce_pkg::ROW_W-1:0] height_last_reg;
    logic [rce_pkg::COL_W-1:0] col_reg, col_next;
    logic [rce_pkg::ROW_W-1:0] row_reg, row_next;
    rce_pkg::pixel_t           left_reg, left_next;

    rce_pkg::pixel_t line_mem [rce_pkg::MAX_WIDTH];
    rce_pkg::pixel_t upper_reg;
    rce_pkg::pixel_t upper_left_reg;

    logic                          s1_valid_reg;
    rce_pkg::pixel_t               s1_cur_reg;
    rce_pkg::pixel_t               s1_left_reg;
    logic [rce_pkg::COL_W-1:0]     s1_col_reg;
    logic [rce_pkg::ROW_W-1:0]     s1_row_reg;
    logic [rce_pkg::NUM_KINDS-1:0] s1_kinds_reg;

    logic                          accept;
    logic                          s1_go;
    logic                          restart;
    logic [rce_pkg::COL_W-1:0]     c;
    logic [rce_pkg::ROW_W-1:0]     r;
    logic                          last_col;
    logic                          last_row;
    logic [rce_pkg::NUM_KINDS-1:0] kinds;
    logic [rce_pkg::SUM_W-1:0]     sum;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_last_reg  <= rce_pkg::COL_W'(rce_pkg::MAX_WIDTH - 1);
            height_last_reg <= rce_pkg::ROW_W'(rce_pkg::MAX_HEIGHT - 1);
        end
        else if (cfg_valid)
        begin
            if (cfg_index == rce_pkg::CFG_IMAGE_WIDTH)
                width_last_reg <= rce_pkg::width_last(cfg_data[rce_pkg::WIDTH_REG_W-1:0]);
            else if (cfg_index == rce_pkg::CFG_IMAGE_HEIGHT)
                height_last_reg <= rce_pkg::height_last(cfg_data);
        end
    end

    // The stage moves on when the queue has room or the item causes no result.
    assign s1_go    = s1_valid_reg && (!job_full || (s1_kinds_reg == '0));
    assign full     = s1_valid_reg && !s1_go;
    assign accept   = push && !full;
    assign job_push = s1_valid_reg && !job_full && (s1_kinds_reg != '0);

    always_comb
    begin
        restart  = (col_reg > width_last_reg) || (row_reg > height_last_reg);
        c        = restart ? '0 : col_reg;
        r        = restart ? '0 : row_reg;
        last_col = (c == width_last_reg);
        last_row = (r == height_last_reg);

        kinds = '0;
        kinds[rce_pkg::KIND_EDGE]  = (r != '0) && (c != '0);
        kinds[rce_pkg::KIND_UPPER] = (r != '0) && last_col;
        kinds[rce_pkg::KIND_SELF]  = last_row;

        if (last_col)
        begin
            col_next  = '0;
            row_next  = last_row ? '0 : r + rce_pkg::ROW_W'(1);
            left_next = '0;
        end
        else
        begin
            col_next  = c + rce_pkg::COL_W'(1);
            row_next  = r;
            left_next = pixel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            left_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_reg  <= col_next;
                row_reg  <= row_next;
                left_reg <= left_next;
            end
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_go)
                s1_valid_reg <= 1'b0;
        end
    end

    // Each pixel is stored at its own column right after the old entry is read,
    // so the buffer always holds the row above the current position.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            upper_reg  <= line_mem[c];
            line_mem[c] <= pixel;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cur_reg   <= pixel;
            s1_left_reg  <= left_reg;
            s1_col_reg   <= c;
            s1_row_reg   <= r;
            s1_kinds_reg <= kinds;
        end
        // The upper-left pixel of an item is the upper pixel of the item before it.
        if (s1_go)
            upper_left_reg <= upper_reg;
    end

    always_comb
    begin
        sum = rce_pkg::SUM_W'(rce_pkg::diag_sum(upper_left_reg, s1_cur_reg))
            + rce_pkg::SUM_W'(rce_pkg::diag_sum(upper_reg, s1_left_reg));

        if (sum > rce_pkg::SUM_W'(rce_pkg::SAT_LIMIT))
            job.magnitude = rce_pkg::CHAN_W'(rce_pkg::SAT_LIMIT);
        else
            job.magnitude = sum[rce_pkg::CHAN_W-1:0];
        job.upper = upper_reg;
        job.cur   = s1_cur_reg;
        job.col   = s1_col_reg;
        job.row   = s1_row_reg;
        job.kinds = s1_kinds_reg;
    end

`ifndef SYNTHESIS
    a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted item did not reach the classify stage");

    a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> !job_full && s1_valid_reg)
        else $error("job pushed into a full queue");

    a_empty_item_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && (s1_kinds_reg == '0)) |-> (s1_go && !job_push))
        else $error("item without results was held or queued");
`endif

endmodule

// File: rtl/rce_queue.sv
module rce_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  rce_pkg::job_t din,
    output logic          full,
    output logic          valid,
    output rce_pkg::job_t dout,
    input  logic          pop
);

    rce_pkg::job_t                store [rce_pkg::QUEUE_DEPTH];
    logic [rce_pkg::QUEUE_AW-1:0] wptr_reg;
    logic [rce_pkg::QUEUE_AW-1:0] rptr_reg;
    logic [rce_pkg::QUEUE_AW:0]   count_reg;

    assign full  = (count_reg == (rce_pkg::QUEUE_AW + 1)'(rce_pkg::QUEUE_DEPTH));
    assign valid = (count_reg != '0);
    assign dout  = store[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= wptr_reg + rce_pkg::QUEUE_AW'(1);
            if (pop)
                rptr_reg <= rptr_reg + rce_pkg::QUEUE_AW'(1);
            if (push && !pop)
                count_reg <= count_reg + (rce_pkg::QUEUE_AW + 1)'(1);
            else if (pop && !push)
                count_reg <= count_reg - (rce_pkg::QUEUE_AW + 1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            store[wptr_reg] <= din;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (rce_pkg::QUEUE_AW + 1)'(rce_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> valid)
        else $error("queue popped while empty");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue pushed while full");
`endif

endmodule

// File: rtl/rce_back.sv
module rce_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             job_valid,
    input  rce_pkg::job_t    job,
    output logic             job_pop,
    output logic             empty,
    input  logic             pop,
    output rce_pkg::result_t result
);

    logic                          out_valid_reg;
    rce_pkg::result_t              out_reg;
    rce_pkg::result_t              out_next;
    logic [rce_pkg::NUM_KINDS-1:0] done_reg;
    logic [rce_pkg::NUM_KINDS-1:0] remaining;
    logic [rce_pkg::NUM_KINDS-1:0] pick;
    logic                          load;
    logic                          last;

    assign empty  = !out_valid_reg;
    assign result = out_reg;
    assign load   = !out_valid_reg || pop;

    always_comb
    begin
        remaining = job.kinds & ~done_reg;
        pick      = '0;
        out_next  = '0;
        priority if (remaining[rce_pkg::KIND_EDGE])
        begin
            pick[rce_pkg::KIND_EDGE] = 1'b1;
            out_next.out_red   = job.magnitude;
            out_next.out_green = job.magnitude;
            out_next.out_blue  = job.magnitude;
            out_next.column    = job.col - rce_pkg::COL_W'(1);
            out_next.row       = job.row - rce_pkg::ROW_W'(1);
            out_next.is_edge   = 1'b1;
        end
        else if (remaining[rce_pkg::KIND_UPPER])
        begin
            pick[rce_pkg::KIND_UPPER] = 1'b1;
            out_next.out_red   = job.upper.red;
            out_next.out_green = job.upper.green;
            out_next.out_blue  = job.upper.blue;
            out_next.column    = job.col;
            out_next.row       = job.row - rce_pkg::ROW_W'(1);
            out_next.is_edge   = 1'b0;
        end
        else
        begin
            pick[rce_pkg::KIND_SELF] = 1'b1;
            out_next.out_red   = job.cur.red;
            out_next.out_green = job.cur.green;
            out_next.out_blue  = job.cur.blue;
            out_next.column    = job.col;
            out_next.row       = job.row;
            out_next.is_edge   = 1'b0;
        end
        last                 = ((remaining & ~pick) == '0);
        out_next.last_of_run = last;
    end

    assign job_pop = job_valid && load && last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            done_reg      <= '0;
        end
        else if (load)
        begin
            out_valid_reg <= job_valid;
            if (job_valid)
                done_reg <= last ? '0 : (done_reg | pick);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && job_valid)
            out_reg <= out_next;
    end

`ifndef SYNTHESIS
    a_pop_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> out_next.last_of_run && load)
        else $error("job left the queue before its final result");

    a_done_subset: assert property (@(posedge clk) disable iff (!rst_n)
        (job_valid && (done_reg != '0)) |-> ((done_reg & ~job.kinds) == '0))
        else $error("emitted mask does not match the head job");

    a_pick_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(pick))
        else $error("result selection is not one-hot");
`endif

endmodule

// File: rtl/roberts_cross_edge_rgb.sv
// An accepted pixel passes the classify stage, job queue and output register before its
// first result shows; extra results of the same pixel follow one per cycle while popped.
// Throughput: one pixel per cycle while each pixel causes at most one result and the output
// is popped; a pixel with two or three results (last column, last row) holds the result
// stage until all have left. Reset (rst_n, asynchronous, active low) returns position, left
// pixel, queue and output to empty and sizes to 1024 by 4096; line buffer is not cleared.
module roberts_cross_edge_rgb (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  rce_pkg::pixel_t                pixel,
    output logic                           empty,
    input  logic                           pop,
    output rce_pkg::result_t               result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  rce_pkg::cfg_idx_t              cfg_index,
    input  logic [rce_pkg::CFG_DATA_W-1:0] cfg_data
);

    // The front end tracks the raster position, reads the row above from the
    // line buffer and computes the Roberts cross magnitude. It hands each item
    // that causes results to a short queue as a job that lists which results
    // (edge, pass-through of the pixel above, pass-through of itself) are due.
    rce_pkg::job_t job_in;
    rce_pkg::job_t job_out;
    logic          job_push;
    logic          job_full;
    logic          job_valid;
    logic          job_pop;

    rce_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .pixel     (pixel),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .job_push  (job_push),
        .job       (job_in),
        .job_full  (job_full)
    );

    // The queue lets the front keep taking pixels while the back end still
    // emits the two or three results of a border pixel.
    rce_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .din   (job_in),
        .full  (job_full),
        .valid (job_valid),
        .dout  (job_out),
        .pop   (job_pop)
    );

    // The back end expands each job into its results, one per cycle while the output is
    // popped or empty, into an output register refilled in the same cycle it is popped.
    rce_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (job_out),
        .job_pop   (job_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule
